[hdl/imm_pkg.sv]
package imm_pkg;

    // Dimensions and widths
    localparam int MAX_DIM   = 8;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * DIM_W;
    localparam int CELLS     = MAX_DIM * MAX_DIM;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);

    // Request modes
    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd_en;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] k;
        logic             first;
        logic             last_k;
        logic             load_out;
        logic             out_last;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic acc_done;
        logic out_full;
    } dp_status_t;

    // Saturate a dimension register and return its last index
    function automatic logic [DIM_W-1:0] eff_last(input logic [CFG_W-1:0] raw);
        logic [CFG_W-1:0] m1;
        m1 = raw - CFG_W'(1);
        if (raw == '0)
            return '0;
        else if (raw > CFG_W'(MAX_DIM))
            return DIM_W'(MAX_DIM - 1);
        else
            return m1[DIM_W-1:0];
    endfunction

endpackage

[hdl/imm_ram.sv]
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

[hdl/imm_datapath.sv]
module imm_datapath
    import imm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic [DIM_W-1:0]   row_index,
    input  logic [DIM_W-1:0]   col_index,
    input  logic [DATA_W-1:0]  element_value,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [DIM_W-1:0]   out_row,
    output logic [DIM_W-1:0]   out_col,
    output logic [DATA_W-1:0]  product_value,
    output logic               last
);

    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] a_raddr;
    logic [ADDR_W-1:0] b_raddr;
    logic [DATA_W-1:0] a_rdata;
    logic [DATA_W-1:0] b_rdata;

    logic              s1_vld_reg, s1_first_reg, s1_last_reg;
    logic              s2_vld_reg, s2_first_reg, s2_last_reg;
    logic [DATA_W-1:0] prod_reg, prod_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              acc_done_reg;
    logic              out_vld_reg;
    logic [DIM_W-1:0]  out_row_reg, out_col_reg;
    logic [DATA_W-1:0] out_val_reg;
    logic              out_last_reg;

    // Row-major addressing into both stores
    assign waddr   = {row_index, col_index};
    assign a_raddr = {cmd.row, cmd.k};
    assign b_raddr = {cmd.k, cmd.col};

    imm_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_a_store (
        .clk   (clk),
        .we    (cmd.wr_a),
        .waddr (waddr),
        .wdata (element_value),
        .re    (cmd.rd_en),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    imm_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_b_store (
        .clk   (clk),
        .we    (cmd.wr_b),
        .waddr (waddr),
        .wdata (element_value),
        .re    (cmd.rd_en),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Low word of the product is the same for signed and unsigned operands
    assign prod_next = a_rdata * b_rdata;
    assign acc_next  = (s2_first_reg ? '0 : acc_reg) + prod_reg;

    // Advance the read and multiply stage flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else
        begin
            s1_vld_reg   <= cmd.rd_en;
            s1_first_reg <= cmd.first;
            s1_last_reg  <= cmd.last_k;
            s2_vld_reg   <= s1_vld_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // Multiply and accumulate
    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
            prod_reg <= prod_next;
        if (s2_vld_reg)
            acc_reg <= acc_next;
    end

    // Hold the finished sum until it moves to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_done_reg <= 1'b0;
        else if (s2_vld_reg && s2_last_reg)
            acc_done_reg <= 1'b1;
        else if (cmd.load_out)
            acc_done_reg <= 1'b0;
    end

    // Output register: set on load, drop on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.load_out)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_row_reg  <= cmd.row;
            out_col_reg  <= cmd.col;
            out_val_reg  <= acc_reg;
            out_last_reg <= cmd.out_last;
        end
    end

    assign status.acc_done = acc_done_reg;
    assign status.out_full = out_vld_reg;

    assign out_valid     = out_vld_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = out_val_reg;
    assign last          = out_last_reg;

endmodule

[hdl/imm_ctrl.sv]
module imm_ctrl
    import imm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [MODE_W-1:0]    mode,
    input  logic                 out_ready,
    input  dp_status_t           status,
    output dp_cmd_t              cmd
);

    ctrl_state_t      state_reg, state_next;
    logic [CFG_W-1:0] row_cfg_reg, inner_cfg_reg, col_cfg_reg;
    logic [DIM_W-1:0] r_reg, r_next;
    logic [DIM_W-1:0] c_reg, c_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic [DIM_W-1:0] row_last, inner_last, col_last;
    logic             accept;
    logic             elem_last;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cfg_reg   <= DIM_RESET;
            inner_cfg_reg <= DIM_RESET;
            col_cfg_reg   <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:   row_cfg_reg   <= cfg_data;
                REG_INNER_COUNT: inner_cfg_reg <= cfg_data;
                REG_COL_COUNT:   col_cfg_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign row_last   = eff_last(row_cfg_reg);
    assign inner_last = eff_last(inner_cfg_reg);
    assign col_last   = eff_last(col_cfg_reg);

    assign accept    = in_valid && in_ready;
    assign elem_last = (r_reg == row_last) && (c_reg == col_last);

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        k_next       = k_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.row      = r_reg;
        cmd.col      = c_reg;
        cmd.k        = k_reg;
        cmd.first    = 1'b0;
        cmd.last_k   = 1'b0;
        cmd.out_last = elem_last;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.wr_a   = accept && (mode == MODE_LOAD_A);
                cmd.wr_b   = accept && (mode == MODE_LOAD_B);
                if (accept && (mode == MODE_COMPUTE))
                begin
                    r_next     = '0;
                    c_next     = '0;
                    k_next     = '0;
                    state_next = ST_READ;
                end
            end

            // Issue one store read per inner step
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.first  = (k_reg == '0);
                cmd.last_k = (k_reg == inner_last);
                if (k_reg == inner_last)
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + DIM_W'(1);
                end
            end

            // Move the sum out once the output register is free
            ST_WAIT:
            begin
                if (status.acc_done && (!status.out_full || out_ready))
                begin
                    cmd.load_out = 1'b1;
                    if (elem_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                        if (c_reg == col_last)
                        begin
                            c_next = '0;
                            r_next = r_reg + DIM_W'(1);
                        end
                        else
                        begin
                            c_next = c_reg + DIM_W'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/integer_matrix_multiply.sv]
// Integer matrix multiply: C = A * B on signed 32-bit elements, wrapped to 32 bits.
//
// Input channel (in_valid/in_ready): each request carries mode, row_index,
// col_index and element_value. Mode 0 writes A[row][col], mode 1 writes
// B[row][col], mode 2 starts a product, mode 3 is dropped. Loads can arrive
// back to back.
// Output channel (out_valid/out_ready): a product request yields row_count by
// col_count results in row-major order, the final one with last set.
// Configuration: cfg_write/cfg_index/cfg_data set row_count, inner_count and
// col_count (0 acts as 1, above 8 acts as 8); write only while idle.
// C elements are computed one at a time, bound by the single read port of
// each store and the one shared multiply-accumulate unit.
// in_ready stays low from a product request until its last element is in the
// output register. A stalled receiver holds the output register and the
// sequencer waits; nothing is lost. Reset sets all dimensions to 8 and
// empties the pipeline; store contents are undefined until loaded.
module integer_matrix_multiply
    import imm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [MODE_W-1:0]        mode,
    input  logic [DIM_W-1:0]         row_index,
    input  logic [DIM_W-1:0]         col_index,
    input  logic signed [DATA_W-1:0] element_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [DIM_W-1:0]         out_row,
    output logic [DIM_W-1:0]         out_col,
    output logic signed [DATA_W-1:0] product_value,
    output logic                     last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    imm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    imm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .last          (last)
    );

endmodule

[hdl/imm_checker.sv]
module imm_checker
    import imm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [MODE_W-1:0]    mode,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [DIM_W-1:0]     out_row,
    input logic [DIM_W-1:0]     out_col,
    input logic [DATA_W-1:0]    product_value,
    input logic                 last
);

    // A product request makes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (mode == MODE_COMPUTE) |=> !in_ready)
    else $error("block took a request right after a product request");

    // The block stays busy while an element other than the last is held
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
    else $error("block idle before the last product element");

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(product_value)
            && $stable(out_row) && $stable(out_col) && $stable(last))
    else $error("stalled result changed");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row       (out_row),
    .out_col       (out_col),
    .product_value (product_value),
    .last          (last)
);

[dv/tb.sv]
import imm_pkg::*;

typedef struct {
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              last;
} product_t;

// Tracks both operand stores and the dimension registers, and owes one
// product element per output cell for every accepted product request.
class product_scoreboard;
    logic [DATA_W-1:0] a_cells [CELLS];
    logic [DATA_W-1:0] b_cells [CELLS];
    bit                a_loaded [CELLS];
    bit                b_loaded [CELLS];
    int                rows  = MAX_DIM;
    int                inner = MAX_DIM;
    int                cols  = MAX_DIM;
    product_t          owed [$];
    int                errors;

    // Clamp a raw dimension to the usable range
    function int saturate(logic [CFG_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (raw > CFG_W'(MAX_DIM))
            return MAX_DIM;
        return int'(raw);
    endfunction

    function void set_dim(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] raw);
        case (idx)
            REG_ROW_COUNT:   rows  = saturate(raw);
            REG_INNER_COUNT: inner = saturate(raw);
            REG_COL_COUNT:   cols  = saturate(raw);
            default:         ;
        endcase
    endfunction

    // Apply one accepted request; a product request queues every element of C
    function void note_request(logic [MODE_W-1:0] m, logic [DIM_W-1:0] r,
                               logic [DIM_W-1:0] c, logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] acc;
        product_t          p;
        case (m)
            MODE_LOAD_A:
            begin
                a_cells[{r, c}]  = v;
                a_loaded[{r, c}] = 1'b1;
            end
            MODE_LOAD_B:
            begin
                b_cells[{r, c}]  = v;
                b_loaded[{r, c}] = 1'b1;
            end
            MODE_COMPUTE:
            begin
                for (int i = 0; i < rows; i++)
                begin
                    for (int j = 0; j < cols; j++)
                    begin
                        acc = '0;
                        for (int k = 0; k < inner; k++)
                            acc += a_cells[i*MAX_DIM + k] * b_cells[k*MAX_DIM + j];
                        p.row   = DIM_W'(i);
                        p.col   = DIM_W'(j);
                        p.value = acc;
                        p.last  = (i == rows - 1) && (j == cols - 1);
                        owed.push_back(p);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Compare one accepted product element with the oldest one owed
    function void check_result(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c,
                               logic [DATA_W-1:0] v, logic lst);
        product_t p;
        if (owed.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected product element: row %0d col %0d value %h last %b",
                         r, c, v, lst);
            return;
        end
        p = owed.pop_front();
        if (p.row !== r || p.col !== c || p.value !== v || p.last !== lst)
        begin
            errors++;
            if (errors <= 10)
                $display({"product mismatch: expected row %0d col %0d value %h last %b,",
                          " got row %0d col %0d value %h last %b"},
                         p.row, p.col, p.value, p.last, r, c, v, lst);
        end
    endfunction
endclass

module tb;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 180;
    localparam int SETTLE_CYCLES = 24;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [MODE_W-1:0]        mode;
    logic [DIM_W-1:0]         row_index;
    logic [DIM_W-1:0]         col_index;
    logic signed [DATA_W-1:0] element_value;
    logic                     out_valid;
    logic                     out_ready;
    logic [DIM_W-1:0]         out_row;
    logic [DIM_W-1:0]         out_col;
    logic signed [DATA_W-1:0] product_value;
    logic                     last;

    product_scoreboard book;
    bit                calm;
    int                items_sent;

    integer_matrix_multiply dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the receiver at random except in calm stretches
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= calm || ($urandom_range(0, 99) >= 18);
    end

    // Check every accepted product element
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            book.check_result(out_row, out_col, product_value, last);
    end

    // Hard stop
    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '1;
            3:       return '0;
            4:       return DATA_W'($urandom_range(0, 15));
            default: return $urandom();
        endcase
    endfunction

    // Mostly small dimensions, now and then zero, full size or beyond
    function automatic logic [CFG_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 75)
            return CFG_W'($urandom_range(1, 3));
        if (roll < 94)
            return CFG_W'($urandom_range(4, 8));
        return CFG_W'($urandom_range(9, 15));
    endfunction

    // Present one request, optionally after a gap, and hold it until accepted
    task automatic send_request(input logic [MODE_W-1:0] m, input logic [DIM_W-1:0] r,
                                input logic [DIM_W-1:0] c, input logic [DATA_W-1:0] v);
        if (!calm && $urandom_range(0, 99) < 18)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        row_index     <= r;
        col_index     <= c;
        element_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        book.note_request(m, r, c, v);
        if (m != MODE_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed element has come and the block is quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (book.owed.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] i,
                              input logic [CFG_W-1:0] c);
        cfg_write <= 1'b1;
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= r;
        @(negedge clk);
        cfg_index <= REG_INNER_COUNT;
        cfg_data  <= i;
        @(negedge clk);
        cfg_index <= REG_COL_COUNT;
        cfg_data  <= c;
        @(negedge clk);
        cfg_write <= 1'b0;
        book.set_dim(REG_ROW_COUNT, r);
        book.set_dim(REG_INNER_COUNT, i);
        book.set_dim(REG_COL_COUNT, c);
    endtask

    // Random loads anywhere or inside the operand region, with unused-mode noise
    task automatic scribble();
        int roll;
        int r;
        int c;
        repeat ($urandom_range(0, 6))
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                send_request(MODE_UNUSED, DIM_W'($urandom()), DIM_W'($urandom()), $urandom());
            else if (roll < 4)
                send_request(roll[0] ? MODE_LOAD_A : MODE_LOAD_B, DIM_W'($urandom()),
                             DIM_W'($urandom()), pick_value());
            else if (roll < 7)
            begin
                r = $urandom_range(0, book.rows - 1);
                c = $urandom_range(0, book.inner - 1);
                send_request(MODE_LOAD_A, DIM_W'(r), DIM_W'(c), pick_value());
            end
            else
            begin
                r = $urandom_range(0, book.inner - 1);
                c = $urandom_range(0, book.cols - 1);
                send_request(MODE_LOAD_B, DIM_W'(r), DIM_W'(c), pick_value());
            end
        end
    endtask

    // Load every operand cell the next product reads that was never written
    task automatic fill_operands();
        for (int r = 0; r < book.rows; r++)
            for (int k = 0; k < book.inner; k++)
                if (!book.a_loaded[r*MAX_DIM + k])
                    send_request(MODE_LOAD_A, DIM_W'(r), DIM_W'(k), pick_value());
        for (int k = 0; k < book.inner; k++)
            for (int c = 0; c < book.cols; c++)
                if (!book.b_loaded[k*MAX_DIM + c])
                    send_request(MODE_LOAD_B, DIM_W'(k), DIM_W'(c), pick_value());
    endtask

    initial
    begin
        int phase;
        book          = new();
        calm          = 1'b0;
        items_sent    = 0;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        mode          = MODE_LOAD_A;
        row_index     = '0;
        col_index     = '0;
        element_value = '0;
        out_ready     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 1x1x1 product with extreme operands; inner count of zero acts as one
        write_dims(4'd1, 4'd0, 4'd1);
        send_request(MODE_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
        send_request(MODE_LOAD_B, 3'd0, 3'd0, 32'h8000_0000);
        send_request(MODE_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff);
        send_request(MODE_UNUSED, 3'd7, 3'd7, 32'h5a5a_a5a5);
        send_request(MODE_LOAD_A, 3'd0, 3'd0, 32'h7fff_ffff);
        send_request(MODE_LOAD_B, 3'd0, 3'd0, 32'h7fff_ffff);
        send_request(MODE_COMPUTE, 3'd0, 3'd0, 32'h0);
        settle();

        // Outer product at full size: row count saturates, inner count of one
        write_dims(4'd15, 4'd0, 4'd8);
        for (int i = 0; i < MAX_DIM; i++)
        begin
            send_request(MODE_LOAD_A, DIM_W'(i), 3'd0, pick_value());
            send_request(MODE_LOAD_B, 3'd0, DIM_W'(i), pick_value());
        end
        send_request(MODE_COMPUTE, 3'd5, 3'd2, 32'h1);

        // Random phases: new dimensions, loads, then one or two products
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            settle();
            calm = (phase >= 4) && (phase < 8);
            write_dims(pick_dim(), pick_dim(), pick_dim());
            scribble();
            fill_operands();
            repeat ($urandom_range(1, 2))
            begin
                send_request(MODE_COMPUTE, DIM_W'($urandom()), DIM_W'($urandom()), $urandom());
                scribble();
            end
            phase++;
        end
        calm = 1'b0;

        settle();
        if (book.errors == 0 && book.owed.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
